// File: design/first_fit_coalescing_allocator_defines.svh
// Assertion helpers shared by the allocator top level.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, idle during reset.
`define FFCA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffca same-cycle check failed");

// Next-cycle implication, clocked on i_clk, idle during reset.
`define FFCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffca next-cycle check failed");

`endif

// File: design/ffca_pkg.sv
`default_nettype none
package ffca_pkg;

    localparam int TABLE_SLOTS_DEF = 512;
    localparam int ADDR_BITS_DEF   = 28;
    localparam int ALIGN_BYTES_DEF = 16;
    localparam int CFG_W           = 29;

    localparam logic [CFG_W-1:0] MEM_SIZE_RST = 29'd134217728;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOMEM    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALIGN,
        S_PASS,
        S_DONE
    } t_state;

    // Which chain tap feeds the tail once the edit point has gone by.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_PREV,
        SH_NEXT1,
        SH_NEXT2
    } t_shift;

endpackage
`default_nettype wire

// File: design/ffca_if.sv
`default_nettype none
interface ffca_req_if #(
    parameter int ADDR_BITS = 28
);
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [ADDR_BITS-1:0] request_size;
    logic [ADDR_BITS-1:0] free_offset;

    modport source (output valid, output opcode, output request_size, output free_offset,
                    input ready);
    modport sink   (input valid, input opcode, input request_size, input free_offset,
                    output ready);
endinterface

interface ffca_rsp_if #(
    parameter int ADDR_BITS = 28,
    parameter int CNT_W     = 10
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] granted_offset;
    logic [CNT_W-1:0]     slots_in_use;
    logic [ADDR_BITS:0]   top_offset;

    modport source (output valid, output status, output granted_offset,
                    output slots_in_use, output top_offset, input ready);
    modport sink   (input valid, input status, input granted_offset,
                    input slots_in_use, input top_offset, output ready);
endinterface
`default_nettype wire

// File: design/ffca_cell.sv
`default_nettype none
module ffca_cell import ffca_pkg::*; #(
    parameter int SW = 2 * ADDR_BITS_DEF + 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire logic [SW-1:0] i_d,
    output logic      [SW-1:0] o_q
);

    logic [SW-1:0] r_q;
    logic [SW-1:0] n_q;

    // Take the neighbor's slot while the chain moves, hold otherwise.
    assign n_q = i_shift ? i_d : r_q;

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// File: design/ffca_align.sv
`default_nettype none
module ffca_align import ffca_pkg::*; #(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [ADDR_BITS-1:0] i_req,
    output logic                      o_done,
    output logic      [ADDR_BITS:0]   o_size
);

    localparam logic [ADDR_BITS:0] A_S = (ADDR_BITS+1)'(ALIGN_BYTES);
    localparam logic [ADDR_BITS:0] A_M = (ADDR_BITS+1)'(ALIGN_BYTES - 1);

    logic               r_done;
    logic [ADDR_BITS:0] r_size;
    logic [ADDR_BITS:0] sum;
    logic [ADDR_BITS:0] rnd;
    logic [ADDR_BITS:0] n_size;

    // Round up by mask (ALIGN_BYTES is a power of two); a zero request takes one unit.
    always_comb begin
        sum    = {1'b0, i_req} + A_M;
        rnd    = sum & ~A_M;
        n_size = (rnd == '0) ? A_S : rnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_size <= n_size;
        end
    end

    assign o_done = r_done;
    assign o_size = r_size;

endmodule
`default_nettype wire

// File: design/ffca_ctrl.sv
`default_nettype none
module ffca_ctrl import ffca_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int SW          = 2 * ADDR_BITS + 2,
    parameter int CW          = $clog2(TABLE_SLOTS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ffca_req_if.sink                  i_req,
    ffca_rsp_if.source                o_rsp,
    input  wire logic [CFG_W-1:0]     i_mem_size,
    output logic                      o_align_start,
    input  wire logic                 i_align_done,
    input  wire logic [ADDR_BITS:0]   i_align_size,
    output logic                      o_shift,
    output logic      [SW-1:0]        o_emit,
    input  wire logic [SW-1:0]        i_c0,
    input  wire logic [SW-1:0]        i_c1,
    input  wire logic [SW-1:0]        i_c2
);

    typedef struct packed {
        logic [ADDR_BITS-1:0] off;
        logic [ADDR_BITS:0]   size;
        logic                 used;
    } t_slot;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int XW = (ADDR_BITS + 2 > CFG_W + 1) ? ADDR_BITS + 2 : CFG_W + 1;
    localparam logic [IW-1:0] T_LAST = IW'(TABLE_SLOTS - 1);
    localparam logic [IW-1:0] T_ONE  = IW'(1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SLOTS);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW:0]   TW_ONE   = (CW+1)'(1);
    localparam logic [CW:0]   TW_TWO   = (CW+1)'(2);
    localparam logic [XW-1:0] ADDR_LIM = XW'(1) << ADDR_BITS;

    t_state r_state, n_state;

    logic                 r_op;
    logic [ADDR_BITS-1:0] r_off;
    logic [ADDR_BITS:0]   r_size;
    logic [IW-1:0]        r_t;
    logic                 r_found;
    t_shift               r_sh;
    t_slot                r_prev;
    logic [CW-1:0]        r_count;
    logic [ADDR_BITS:0]   r_hw;
    logic [CW-1:0]        r_new_count;
    logic [ADDR_BITS:0]   r_new_hw;
    logic [ADDR_BITS-1:0] r_grant;

    logic                 r_rsp_valid;
    t_status              r_rsp_status;
    logic [ADDR_BITS-1:0] r_rsp_grant;
    logic [CW-1:0]        r_rsp_slots;
    logic [ADDR_BITS:0]   r_rsp_top;

    t_slot                c0, c1, c2;
    logic [CW:0]          tw, cnt1;
    logic                 v0, v1, v2;
    logic [XW-1:0]        ext_sum;
    logic                 nomem;
    logic                 done_go;
    t_status              fail_status;

    t_slot                f_emit;
    t_slot                f_prev;
    logic                 f_hit;
    t_shift               f_sh;
    logic [CW-1:0]        f_count;
    logic [ADDR_BITS:0]   f_hw;
    logic [ADDR_BITS-1:0] f_grant;
    logic                 d2;
    logic [1:0]           dd;
    logic [ADDR_BITS:0]   msum;
    logic                 mlast;

    assign c0 = t_slot'(i_c0);
    assign c1 = t_slot'(i_c1);
    assign c2 = t_slot'(i_c2);

    always_comb begin
        tw   = (CW+1)'(r_t);
        cnt1 = {1'b0, r_count};
        v0   = tw < cnt1;
        v1   = (tw + TW_ONE) < cnt1;
        v2   = (tw + TW_TWO) < cnt1;
        ext_sum = XW'(r_hw) + XW'(r_size);
        nomem   = (ext_sum > XW'(i_mem_size)) || (ext_sum > ADDR_LIM);
        done_go = (r_state == S_DONE) && (!r_rsp_valid || o_rsp.ready);
        if (r_op == OP_FREE) begin
            fail_status = ST_NOTFOUND;
        end else if (nomem) begin
            fail_status = ST_NOMEM;
        end else begin
            fail_status = ST_FULL;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_ALIGN;
            S_ALIGN: if (i_align_done) n_state = S_PASS;
            S_PASS:  if (r_t == T_LAST) n_state = S_DONE;
            S_DONE:  if (done_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        i_req.ready   = (r_state == S_IDLE);
        o_align_start = (r_state == S_IDLE) && i_req.valid;
        o_shift       = (r_state == S_PASS);
    end

    // Slot editor: decide what the tail cell takes this cycle.
    always_comb begin
        f_hit   = 1'b0;
        f_sh    = r_sh;
        f_prev  = c0;
        f_count = r_new_count;
        f_hw    = r_new_hw;
        f_grant = r_grant;
        d2      = 1'b0;
        dd      = 2'd0;
        msum    = '0;
        mlast   = 1'b0;
        case (r_sh)
            SH_PREV:  f_emit = r_prev;
            SH_NEXT1: f_emit = c1;
            SH_NEXT2: f_emit = c2;
            default:  f_emit = c0;
        endcase
        if (!r_found) begin
            if (r_op == OP_ALLOC) begin
                if (v0 && !c0.used && c0.size >= r_size) begin
                    f_hit   = 1'b1;
                    f_grant = c0.off;
                    if (c0.size != r_size && r_count != FULL_CNT) begin
                        // Split: used front now, free rest next cycle.
                        f_emit  = '{off: c0.off, size: r_size, used: 1'b1};
                        f_prev  = '{off: c0.off + r_size[ADDR_BITS-1:0],
                                    size: c0.size - r_size, used: 1'b0};
                        f_sh    = SH_PREV;
                        f_count = r_count + CNT_ONE;
                    end else begin
                        f_emit  = '{off: c0.off, size: c0.size, used: 1'b1};
                        f_sh    = SH_NONE;
                    end
                end else if (tw == cnt1 && !nomem) begin
                    // No hole fits: extend at the top.
                    f_hit   = 1'b1;
                    f_grant = r_hw[ADDR_BITS-1:0];
                    f_emit  = '{off: r_hw[ADDR_BITS-1:0], size: r_size, used: 1'b1};
                    f_sh    = SH_NONE;
                    f_count = r_count + CNT_ONE;
                    f_hw    = r_hw + r_size;
                end
            end else begin
                if (v0 && v1 && !c0.used && c1.used && c1.off == r_off) begin
                    // Target is next, and this free hole absorbs it.
                    f_hit = 1'b1;
                    d2    = v2 && !c2.used;
                    dd    = d2 ? 2'd2 : 2'd1;
                    msum  = c0.size + c1.size + (d2 ? c2.size : '0);
                    f_sh  = d2 ? SH_NEXT2 : SH_NEXT1;
                end else if (v0 && c0.used && c0.off == r_off) begin
                    f_hit = 1'b1;
                    d2    = v1 && !c1.used;
                    dd    = d2 ? 2'd1 : 2'd0;
                    msum  = c0.size + (d2 ? c1.size : '0);
                    f_sh  = d2 ? SH_NEXT1 : SH_NONE;
                end
                if (f_hit) begin
                    f_emit = '{off: c0.off, size: msum, used: 1'b0};
                    mlast  = (tw + (CW+1)'(dd) + TW_ONE) == cnt1;
                    // Drop the merged hole if it ends up at the top.
                    if (mlast) begin
                        f_count = tw[CW-1:0];
                        f_hw    = {1'b0, c0.off};
                    end else begin
                        f_count = r_count - CW'(dd);
                    end
                end
            end
        end
    end

    assign o_emit = f_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hw        <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done_go) begin
                r_count     <= r_new_count;
                r_hw        <= r_new_hw;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_op  <= i_req.opcode;
            r_off <= i_req.free_offset;
        end
        if (r_state == S_ALIGN && i_align_done) begin
            r_size      <= i_align_size;
            r_t         <= '0;
            r_found     <= 1'b0;
            r_sh        <= SH_NONE;
            r_new_count <= r_count;
            r_new_hw    <= r_hw;
            r_grant     <= '0;
        end
        if (r_state == S_PASS) begin
            r_t    <= r_t + T_ONE;
            r_prev <= f_prev;
            r_sh   <= f_sh;
            if (f_hit) begin
                r_found     <= 1'b1;
                r_new_count <= f_count;
                r_new_hw    <= f_hw;
                r_grant     <= f_grant;
            end
        end
        if (done_go) begin
            r_rsp_status <= r_found ? ST_OK : fail_status;
            r_rsp_grant  <= r_grant;
            r_rsp_slots  <= r_new_count;
            r_rsp_top    <= r_new_hw;
        end
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.status         = r_rsp_status;
    assign o_rsp.granted_offset = r_rsp_grant;
    assign o_rsp.slots_in_use   = r_rsp_slots;
    assign o_rsp.top_offset     = r_rsp_top;

endmodule
`default_nettype wire

// File: design/first_fit_coalescing_allocator.sv
// First-fit allocator with free-hole coalescing over a region of i_cfg_wdata bytes.
// Request channel i_req (valid/ready): opcode 0 allocates request_size bytes,
// rounded up to ALIGN_BYTES; opcode 1 frees the block starting at free_offset.
// Response channel o_rsp (valid/ready): status, granted_offset, slots_in_use
// and top_offset, one response per request, in order.
// Configuration: write i_cfg_wdata with i_cfg_we high while no request is open;
// it sets the memory limit used when the block extends at the top.
// Processing: size rounding by mask in the align stage, then one full rotation
// of the slot chain, one cell per cycle, during which the slot table is searched
// and edited in place, then a load of the response register.
// A request is accepted only in the idle state, so the next one waits until
// the current pass through the slot chain has finished.
// A new request is taken while the previous response waits in its output
// register; if the receiver stalls, the next response holds in the final
// state until the output register frees.
// Reset (synchronous, active low) empties the table, clears the top mark and
// restores the memory limit to 128 MiB. The slot cells need no clearing.
`default_nettype none
`include "first_fit_coalescing_allocator_defines.svh"
module first_fit_coalescing_allocator import ffca_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    ffca_req_if.sink              i_req,
    ffca_rsp_if.source            o_rsp
);

    localparam int SW = 2 * ADDR_BITS + 2;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [ADDR_BITS:0] TOP_MAX = (ADDR_BITS+1)'(1) << ADDR_BITS;
    localparam logic [CW-1:0]      SLOT_MAX = CW'(TABLE_SLOTS);

    logic [CFG_W-1:0]   r_mem_size;
    logic               align_start;
    logic               align_done;
    logic [ADDR_BITS:0] align_size;
    logic               shift;
    logic [SW-1:0]      emit;
    logic [SW-1:0]      w_q [TABLE_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= MEM_SIZE_RST;
        end else if (i_cfg_we) begin
            r_mem_size <= i_cfg_wdata;
        end
    end

    ffca_align #(
        .ADDR_BITS   (ADDR_BITS),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (align_start),
        .i_req   (i_req.request_size),
        .o_done  (align_done),
        .o_size  (align_size)
    );

    // Slot chain: cell 0 is the head seen by the editor, the tail takes its output.
    for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
        if (k == TABLE_SLOTS - 1) begin : g_tail
            ffca_cell #(.SW(SW)) u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_d     (emit),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            ffca_cell #(.SW(SW)) u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_d     (w_q[k+1]),
                .o_q     (w_q[k])
            );
        end
    end

    ffca_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .ADDR_BITS   (ADDR_BITS),
        .SW          (SW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .i_mem_size    (r_mem_size),
        .o_align_start (align_start),
        .i_align_done  (align_done),
        .i_align_size  (align_size),
        .o_shift       (shift),
        .o_emit        (emit),
        .i_c0          (w_q[0]),
        .i_c1          (w_q[1]),
        .i_c2          (w_q[2])
    );

    `FFCA_ASSERT_NEXT(a_one_at_a_time, i_req.valid && i_req.ready, !i_req.ready)
    `FFCA_ASSERT_SAME(a_grant_zero_on_fail, o_rsp.valid && o_rsp.status != ST_OK, o_rsp.granted_offset == '0)
    `FFCA_ASSERT_SAME(a_slots_bound, o_rsp.valid, o_rsp.slots_in_use <= SLOT_MAX)
    `FFCA_ASSERT_SAME(a_top_bound, o_rsp.valid, o_rsp.top_offset <= TOP_MAX)

endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
module tb_top import ffca_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT   = TABLE_SLOTS_DEF;
    localparam int ABITS   = ADDR_BITS_DEF;
    localparam int ALIGN   = ALIGN_BYTES_DEF;
    localparam int LATENCY = ABITS + NSLOT + 3;

    typedef struct packed {
        t_status        status;
        logic [ABITS-1:0] granted;
        logic [9:0]     slots;
        logic [ABITS:0] top;
    } t_alloc_rsp;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    ffca_req_if #(.ADDR_BITS(ABITS)) req_if ();
    ffca_rsp_if #(.ADDR_BITS(ABITS), .CNT_W(10)) rsp_if ();

    first_fit_coalescing_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow of the slot table and allocator state
    longint     slot_off [NSLOT];
    longint     slot_len [NSLOT];
    bit         slot_used[NSLOT];
    int         slot_cnt;
    longint     top_mark;
    longint     mem_limit;

    t_alloc_rsp pending_rsp[$];
    int         fail_cnt = 0;
    int         sent_cnt;
    int         rsp_cnt = 0;
    int         src_idle_pct;
    int         snk_idle_pct;
    int         rsp_hold_cycles = 0;
    bit         hold_tgl = 1'b0;
    bit         hold_seen = 1'b0;

    function automatic void drop_slot(int k);
        for (int j = k; j + 1 < slot_cnt; j++) begin
            slot_off[j]  = slot_off[j+1];
            slot_len[j]  = slot_len[j+1];
            slot_used[j] = slot_used[j+1];
        end
        slot_cnt--;
    endfunction

    function automatic t_alloc_rsp predict_alloc(logic op, logic [ABITS-1:0] rsize,
                                                 logic [ABITS-1:0] foff);
        t_alloc_rsp r;
        longint     sz;
        longint     lim;
        bit         hit;
        int         i;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        if (op == OP_ALLOC) begin
            sz = ((longint'(rsize) + ALIGN - 1) / ALIGN) * ALIGN;
            if (sz == 0) sz = ALIGN;
            for (i = 0; i < slot_cnt; i++) begin
                if (!slot_used[i] && slot_len[i] >= sz) begin
                    // split unless the table is full; then take the whole hole
                    if (slot_len[i] != sz && slot_cnt < NSLOT) begin
                        for (int j = slot_cnt; j > i; j--) begin
                            slot_off[j]  = slot_off[j-1];
                            slot_len[j]  = slot_len[j-1];
                            slot_used[j] = slot_used[j-1];
                        end
                        slot_cnt++;
                        slot_len[i] = sz;
                        slot_off[i+1] += sz;
                        slot_len[i+1] -= sz;
                    end
                    slot_used[i] = 1'b1;
                    r.granted = slot_off[i][ABITS-1:0];
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit) begin
                lim = (mem_limit > (64'd1 << ABITS)) ? (64'd1 << ABITS) : mem_limit;
                if (top_mark + sz > lim) begin
                    r.status = ST_NOMEM;
                end else if (slot_cnt >= NSLOT) begin
                    r.status = ST_FULL;
                end else begin
                    slot_off[slot_cnt]  = top_mark;
                    slot_len[slot_cnt]  = sz;
                    slot_used[slot_cnt] = 1'b1;
                    slot_cnt++;
                    r.granted = top_mark[ABITS-1:0];
                    top_mark += sz;
                end
            end
        end else begin
            r.status = ST_NOTFOUND;
            for (i = 0; i < slot_cnt; i++) begin
                if (slot_used[i] && slot_off[i] == longint'(foff)) begin
                    slot_used[i] = 1'b0;
                    // merge with successor, then predecessor
                    if (i + 1 < slot_cnt && !slot_used[i+1]) begin
                        slot_len[i] += slot_len[i+1];
                        drop_slot(i + 1);
                    end
                    if (i > 0 && !slot_used[i-1]) begin
                        slot_len[i-1] += slot_len[i];
                        drop_slot(i);
                    end
                    while (slot_cnt > 0 && !slot_used[slot_cnt-1]) slot_cnt--;
                    top_mark = (slot_cnt == 0) ? 0 :
                               slot_off[slot_cnt-1] + slot_len[slot_cnt-1];
                    r.status = ST_OK;
                    break;
                end
            end
        end
        r.slots = slot_cnt[9:0];
        r.top   = top_mark[ABITS:0];
        return r;
    endfunction

    function automatic logic [ABITS-1:0] pick_live_offset();
        int n;
        int k;
        n = 0;
        for (int i = 0; i < slot_cnt; i++) if (slot_used[i]) n++;
        if (n == 0) return '0;
        k = $urandom_range(n - 1);
        for (int i = 0; i < slot_cnt; i++) begin
            if (slot_used[i]) begin
                if (k == 0) return slot_off[i][ABITS-1:0];
                k--;
            end
        end
        return '0;
    endfunction

    // Send one request; valid stays high until the caller idles or a random gap drops it
    task automatic send_request(logic op, logic [ABITS-1:0] rsize, logic [ABITS-1:0] foff);
        int gap;
        req_if.valid        <= 1'b1;
        req_if.opcode       <= op;
        req_if.request_size <= rsize;
        req_if.free_offset  <= foff;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_rsp.push_back(predict_alloc(op, rsize, foff));
        sent_cnt++;
        if ($urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(1, 4);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mem_limit(logic [CFG_W-1:0] value);
        wait_drained();
        repeat (LATENCY) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mem_limit = longint'(value);
    endtask

    task automatic test_directed();
        send_request(OP_ALLOC, '0, '1);                // zero size takes one unit
        send_request(OP_ALLOC, 28'd1, '0);
        send_request(OP_ALLOC, 28'd17, 28'h5555555);
        send_request(OP_ALLOC, 28'hFFFFFFF, '0);       // rounds past the region
        send_request(OP_FREE, '1, 28'd8);              // inside a block
        send_request(OP_FREE, '0, 28'd16);
        send_request(OP_FREE, '0, 28'd16);             // now a hole
        send_request(OP_ALLOC, 28'h1, 28'hAAAAAAA);    // refill hole
        send_request(OP_FREE, '0, 28'd32);             // drops from top
        send_request(OP_FREE, '0, 28'd0);
        send_request(OP_FREE, '0, 28'd16);             // empties table
        send_request(OP_ALLOC, 28'd48, '0);
        send_request(OP_ALLOC, 28'd16, '0);
        send_request(OP_ALLOC, 28'd16, '0);
        send_request(OP_FREE, '0, 28'd64);
        send_request(OP_FREE, '0, 28'd0);              // no free neighbour to merge with
        send_request(OP_FREE, '0, 28'd48);             // merge with predecessor, then drops from top
        send_request(OP_FREE, '0, 28'hFFFFFFF);
        wait_drained();
    endtask

    task automatic test_table_full();
        send_request(OP_ALLOC, 28'd64, '0);
        while (slot_cnt < NSLOT)
            send_request(OP_ALLOC, ABITS'($urandom_range(1, 16)), ABITS'($urandom()));
        send_request(OP_FREE, '0, 28'd0);
        send_request(OP_ALLOC, 28'd16, '0);            // full: whole hole is used
        send_request(OP_ALLOC, 28'd16, '0);
        write_mem_limit('0);
        send_request(OP_ALLOC, 28'd16, '0);            // both limits hit
        wait_drained();
    endtask

    task automatic test_random(int count, logic [CFG_W-1:0] limit_val);
        int pick;
        write_mem_limit(limit_val);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_request(OP_ALLOC, ABITS'($urandom_range(0, 400)), ABITS'($urandom()));
            else if (pick < 50)
                send_request(OP_ALLOC, ABITS'($urandom()), ABITS'($urandom()));
            else if (pick < 90)
                send_request(OP_FREE, ABITS'($urandom()), pick_live_offset());
            else
                send_request(OP_FREE, ABITS'($urandom()), ABITS'($urandom()));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_tgl = ~hold_tgl;
        for (int n = 0; n < 6; n++) send_request(OP_ALLOC, ABITS'($urandom_range(0, 64)), '0);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_tgl != hold_seen) begin
            hold_seen       <= hold_tgl;
            rsp_hold_cycles <= 3000;
            rsp_if.ready    <= 1'b0;
        end else if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles <= rsp_hold_cycles - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_alloc_rsp e;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_cnt++;
            if (pending_rsp.size() == 0) begin
                $error("unexpected response");
                fail_cnt++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_if.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, rsp_if.status);
                    fail_cnt++;
                end
                if (rsp_if.granted_offset !== e.granted) begin
                    $error("granted_offset expected %0h actual %0h",
                           e.granted, rsp_if.granted_offset);
                    fail_cnt++;
                end
                if (rsp_if.slots_in_use !== e.slots) begin
                    $error("slots_in_use expected %0d actual %0d", e.slots, rsp_if.slots_in_use);
                    fail_cnt++;
                end
                if (rsp_if.top_offset !== e.top) begin
                    $error("top_offset expected %0h actual %0h", e.top, rsp_if.top_offset);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        req_if.valid        = 1'b0;
        req_if.opcode       = OP_ALLOC;
        req_if.request_size = '0;
        req_if.free_offset  = '0;
        slot_cnt = 0;
        top_mark = 0;
        mem_limit = longint'(MEM_SIZE_RST);
        sent_cnt = 0;
        src_idle_pct = 16;
        snk_idle_pct = 60;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_table_full();
        test_random(14, 29'd4096);
        src_idle_pct = 60;
        snk_idle_pct = 16;
        test_random(14, 29'h1FFFFFFF);
        test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(10, 29'd268435456);
        test_random(6, 29'd1024);

        wait_drained();
        repeat (LATENCY) @(posedge i_clk);
        $display("Sent %0d requests, checked %0d responses: splits, merges, full table,",
                 sent_cnt, rsp_cnt);
        $display("limit changes incl. zero and beyond the address space, response stalls.");
        if (fail_cnt == 0 && pending_rsp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+design
design/ffca_pkg.sv
design/ffca_if.sv
design/ffca_cell.sv
design/ffca_align.sv
design/ffca_ctrl.sv
design/first_fit_coalescing_allocator.sv
test/tb_top.sv
